[hdl/assert_macros.svh]
// Shared assertion macros, sampled on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Condition must never be true out of reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

[hdl/htc_pkg.sv]
// ---------------------------------------------------------------------------
// htc_pkg
// Types, constants and helpers of the homogeneous triangle clipper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package htc_pkg;

  localparam int MAX_POLY_VERTS = 10;
  localparam int IDX_W = $clog2(MAX_POLY_VERTS);
  localparam int CNT_W = $clog2(MAX_POLY_VERTS + 1);
  localparam int CFG_IDX_W = 2;
  localparam int LIMIT_W = 31;
  localparam int Q_DEPTH = 2;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR  = 2'd1;
  localparam logic [LIMIT_W-1:0] NEAR_RESET = 31'd6554;
  localparam logic [LIMIT_W-1:0] FAR_RESET  = 31'd6553600;

  localparam logic [2:0] PL_XP = 3'd0;
  localparam logic [2:0] PL_XN = 3'd1;
  localparam logic [2:0] PL_YP = 3'd2;
  localparam logic [2:0] PL_YN = 3'd3;
  localparam logic [2:0] PL_ZP = 3'd4;
  localparam logic [2:0] PL_ZN = 3'd5;
  localparam logic [2:0] PL_WE = 3'd6;

  localparam logic [2:0] FD_X  = 3'd0;
  localparam logic [2:0] FD_Y  = 3'd1;
  localparam logic [2:0] FD_Z  = 3'd2;
  localparam logic [2:0] FD_W  = 3'd3;
  localparam logic [2:0] FD_WB = 3'd4;
  localparam logic [2:0] FD_WC = 3'd5;

  typedef struct packed {
    logic signed [31:0] ax, ay, az, aw;
    logic signed [31:0] bx, by, bz, bw;
    logic signed [31:0] cx, cy, cz, cw;
  } tri_t;

  typedef struct packed {
    logic signed [31:0] out_x, out_y, out_z, out_w;
    logic [16:0]        weight_b, weight_c;
    logic               last_vertex;
  } vtx_t;

  typedef struct packed {
    logic signed [31:0] x, y, z, w;
    logic [16:0]        wb, wc;
  } pvert_t;

  typedef struct packed {
    tri_t tri_d;
    logic pass;
  } qitem_t;

  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    sx33 = {v[31], v};
  endfunction

  function automatic logic signed [32:0] plane_dist(input pvert_t v, input logic [2:0] p);
    logic signed [32:0] w;
    w = sx33(v.w);
    unique case (p)
      PL_XP:   plane_dist = w - sx33(v.x);
      PL_XN:   plane_dist = w + sx33(v.x);
      PL_YP:   plane_dist = w - sx33(v.y);
      PL_YN:   plane_dist = w + sx33(v.y);
      PL_ZP:   plane_dist = w - sx33(v.z);
      PL_ZN:   plane_dist = w + sx33(v.z);
      default: plane_dist = w - 33'sd1;
    endcase
  endfunction

  function automatic logic signed [32:0] field_get(input pvert_t v, input logic [2:0] f);
    unique case (f)
      FD_X:    field_get = sx33(v.x);
      FD_Y:    field_get = sx33(v.y);
      FD_Z:    field_get = sx33(v.z);
      FD_W:    field_get = sx33(v.w);
      FD_WB:   field_get = {16'd0, v.wb};
      default: field_get = {16'd0, v.wc};
    endcase
  endfunction

endpackage
`default_nettype wire

[hdl/homogeneous_triangle_clipper.sv]
// Trivial accept skips clipping and streams the loaded triangle; trivial reject gives no beat.
// Clipping: per plane each input vertex is classified, and each crossing runs the divider,
// then saturation, then 6 fields through the one shared multiplier.
// Throughput: one triangle at a time in the back end; two more wait in the queue.
// Reset: rst clears queue, sequencer, beat; limits to defaults.
// ---------------------------------------------------------------------------
// homogeneous_triangle_clipper
// Clip-space triangle clipper emitting polygon vertices with barycentric weights.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_triangle_clipper (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tri_valid,
  output logic                               tri_stall,
  input  wire htc_pkg::tri_t                 tri_data,
  output logic                               vtx_valid,
  input  wire logic                          vtx_stall,
  output htc_pkg::vtx_t                      vtx_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [htc_pkg::LIMIT_W-1:0]   cfg_data
);
  import htc_pkg::*;

  logic q_full, q_push, q_ne, q_pop;
  qitem_t q_wr, q_rd;

  htc_front u_front (
    .clk(clk), .rst(rst),
    .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_full(q_full), .q_push(q_push), .q_item(q_wr)
  );

  htc_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(q_push), .wr_item(q_wr), .full(q_full),
    .not_empty(q_ne), .pop(q_pop), .rd_item(q_rd)
  );

  htc_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_ne), .q_item(q_rd), .q_pop(q_pop),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx_data(vtx_data)
  );

endmodule
`default_nettype wire

[hdl/htc_front.sv]
// ---------------------------------------------------------------------------
// htc_front
// Limit registers, trivial accept / reject classification and queue push.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module htc_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tri_valid,
  output logic                               tri_stall,
  input  wire htc_pkg::tri_t                 tri_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [htc_pkg::LIMIT_W-1:0]   cfg_data,
  input  wire logic                          q_full,
  output logic                               q_push,
  output htc_pkg::qitem_t                    q_item
);
  import htc_pkg::*;

  logic [LIMIT_W-1:0] near_limit, far_limit;
  logic signed [32:0] nr, fr;
  logic signed [32:0] c [3][3];
  logic signed [32:0] w [3];
  logic [2:0] ins;
  logic [7:0] rej;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= NEAR_RESET;
      far_limit  <= FAR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_NEAR) near_limit <= cfg_data;
      else if (cfg_index == REG_FAR) far_limit <= cfg_data;
    end
  end

  assign nr = {2'b00, near_limit};
  assign fr = {2'b00, far_limit};

  always_comb begin
    c[0][0] = sx33(tri_data.ax); c[0][1] = sx33(tri_data.ay);
    c[0][2] = sx33(tri_data.az); w[0]    = sx33(tri_data.aw);
    c[1][0] = sx33(tri_data.bx); c[1][1] = sx33(tri_data.by);
    c[1][2] = sx33(tri_data.bz); w[1]    = sx33(tri_data.bw);
    c[2][0] = sx33(tri_data.cx); c[2][1] = sx33(tri_data.cy);
    c[2][2] = sx33(tri_data.cz); w[2]    = sx33(tri_data.cw);
    rej = 8'hFF;
    for (int i = 0; i < 3; i++) begin
      ins[i] = (w[i] <= fr) && (w[i] >= nr);
      if (!(w[i] < nr)) rej[0] = 1'b0;
      if (!(w[i] > fr)) rej[1] = 1'b0;
      for (int k = 0; k < 3; k++) begin
        if (c[i][k] > w[i] || c[i][k] < -w[i]) ins[i] = 1'b0;
        if (!(c[i][k] > w[i]))  rej[2 + 2*k] = 1'b0;
        if (!(c[i][k] < -w[i])) rej[3 + 2*k] = 1'b0;
      end
    end
  end

  assign tri_stall    = q_full;
  assign q_item.tri_d = tri_data;
  assign q_item.pass  = &ins;
  assign q_push       = tri_valid && !q_full && ((&ins) || !(|rej));

endmodule
`default_nettype wire

[hdl/htc_fifo.sv]
// ---------------------------------------------------------------------------
// htc_fifo
// Short queue of classified triangles between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module htc_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire htc_pkg::qitem_t wr_item,
  output logic                 full,
  output logic                 not_empty,
  input  wire logic            pop,
  output htc_pkg::qitem_t      rd_item
);
  import htc_pkg::*;

  qitem_t slot [Q_DEPTH];
  logic wptr, rptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `ASSERT_NEVER(a_q_overflow, push && full && !pop)
  `ASSERT_CLK(a_q_count, (pop && !push) |=> (count == $past(count) - 1'b1))

endmodule
`default_nettype wire

[hdl/htc_back.sv]
// ---------------------------------------------------------------------------
// htc_back
// Plane-by-plane clipping sequencer with shared divider and interpolator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module htc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire htc_pkg::qitem_t q_item,
  output logic                 q_pop,
  output logic                 vtx_valid,
  input  wire logic            vtx_stall,
  output htc_pkg::vtx_t        vtx_data
);
  import htc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_LOAD = 5'd1,  S_PST = 5'd2,  S_PPRV = 5'd3;
  localparam logic [4:0] S_RD   = 5'd4,  S_LD   = 5'd5,  S_CHK = 5'd6,  S_DIV0 = 5'd7;
  localparam logic [4:0] S_DIV  = 5'd8,  S_TSAT = 5'd9,  S_LM  = 5'd10, S_LA   = 5'd11;
  localparam logic [4:0] S_WRX  = 5'd12, S_WRE  = 5'd13, S_ADV = 5'd14, S_PEND = 5'd15;
  localparam logic [4:0] S_EMRD = 5'd16, S_EMWT = 5'd17;
  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

  logic [4:0] state;
  pvert_t mem [MEM_DEPTH];
  pvert_t rdata, wdata, prev, cur, newv, ld_v;
  logic [IDX_W:0] raddr, waddr;
  logic we;

  tri_t tri_r;
  logic pass;
  logic [1:0] li;
  logic src;
  logic [2:0] plane, fld;
  logic [CNT_W-1:0] n, m, i, e;
  logic in1;
  logic [33:0] num, den;
  logic [33:0] rem;
  logic [34:0] rem2;
  logic [16:0] q, t;
  logic [3:0] dcnt;
  logic signed [32:0] d0, d1, fa, fb;
  logic signed [33:0] dd, diff;
  logic signed [51:0] prod, sh, res;
  logic out_free;

  assign out_free = !vtx_valid || !vtx_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_comb begin
    unique case (li)
      2'd0:    ld_v = '{x: tri_r.ax, y: tri_r.ay, z: tri_r.az, w: tri_r.aw,
                        wb: 17'd0, wc: 17'd0};
      2'd1:    ld_v = '{x: tri_r.bx, y: tri_r.by, z: tri_r.bz, w: tri_r.bw,
                        wb: ONE_Q16, wc: 17'd0};
      default: ld_v = '{x: tri_r.cx, y: tri_r.cy, z: tri_r.cz, w: tri_r.cw,
                        wb: 17'd0, wc: ONE_Q16};
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = {~src, m[IDX_W-1:0]};
    wdata = cur;
    raddr = {src, i[IDX_W-1:0]};
    unique case (state)
      S_LOAD: begin
        we    = 1'b1;
        waddr = {1'b0, IDX_W'(li)};
        wdata = ld_v;
      end
      S_WRX: begin
        we    = (m < CNT_W'(MAX_POLY_VERTS));
        wdata = newv;
      end
      S_WRE:  we = (m < CNT_W'(MAX_POLY_VERTS));
      S_PST: begin
        raddr = {src, IDX_W'(n - 1'b1)};
      end
      S_EMRD, S_EMWT: raddr = {src, e[IDX_W-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign d0   = plane_dist(prev, plane);
  assign d1   = plane_dist(cur, plane);
  assign dd   = {d0[32], d0} - {d1[32], d1};
  assign rem2 = {rem, 1'b0};
  assign fa   = field_get(prev, fld);
  assign fb   = field_get(cur, fld);
  assign diff = {fb[32], fb} - {fa[32], fa};
  assign sh   = (prod + 52'sd32768) >>> 16;
  assign res  = {{19{fa[32]}}, fa} + sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vtx_valid <= 1'b0;
    end else begin
      if ((state == S_EMWT) && out_free) vtx_valid <= 1'b1;
      else if (!vtx_stall)               vtx_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid) begin
          tri_r <= q_item.tri_d;
          pass  <= q_item.pass;
          li    <= 2'd0;
          src   <= 1'b0;
          state <= S_LOAD;
        end
        S_LOAD: begin
          li <= li + 1'b1;
          if (li == 2'd2) begin
            n     <= CNT_W'(3);
            e     <= '0;
            plane <= PL_XP;
            state <= pass ? S_EMRD : S_PST;
          end
        end
        S_PST: begin
          m <= '0;
          i <= '0;
          state <= (n == '0) ? S_PEND : S_PPRV;
        end
        S_PPRV: begin
          prev  <= rdata;
          state <= S_RD;
        end
        S_RD: state <= S_LD;
        S_LD: begin
          cur   <= rdata;
          state <= S_CHK;
        end
        S_CHK: begin
          in1 <= !d1[32];
          num <= d0[32] ? 34'(-{d0[32], d0}) : 34'({d0[32], d0});
          den <= dd[33] ? 34'(-dd) : 34'(dd);
          if (d0[32] != d1[32]) state <= S_DIV0;
          else if (!d1[32])     state <= S_WRE;
          else                  state <= S_ADV;
        end
        S_DIV0: begin
          if (num >= den) begin
            rem <= num - den;
            q   <= 17'd1;
          end else begin
            rem <= num;
            q   <= 17'd0;
          end
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem2 >= {1'b0, den}) begin
            rem <= 34'(rem2 - {1'b0, den});
            q   <= {q[15:0], 1'b1};
          end else begin
            rem <= rem2[33:0];
            q   <= {q[15:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 4'd15) state <= S_TSAT;
        end
        S_TSAT: begin
          t     <= (q > ONE_Q16) ? ONE_Q16 : q;
          fld   <= FD_X;
          state <= S_LM;
        end
        S_LM: begin
          prod  <= diff * $signed({1'b0, t});
          state <= S_LA;
        end
        S_LA: begin
          unique case (fld)
            FD_X:    newv.x  <= res[31:0];
            FD_Y:    newv.y  <= res[31:0];
            FD_Z:    newv.z  <= res[31:0];
            FD_W:    newv.w  <= res[31:0];
            FD_WB:   newv.wb <= res[16:0];
            default: newv.wc <= res[16:0];
          endcase
          fld   <= fld + 1'b1;
          state <= (fld == FD_WC) ? S_WRX : S_LM;
        end
        S_WRX: begin
          if (we) m <= m + 1'b1;
          state <= in1 ? S_WRE : S_ADV;
        end
        S_WRE: begin
          if (we) m <= m + 1'b1;
          state <= S_ADV;
        end
        S_ADV: begin
          prev <= cur;
          i    <= i + 1'b1;
          state <= (i == n - 1'b1) ? S_PEND : S_RD;
        end
        S_PEND: begin
          n     <= m;
          src   <= ~src;
          plane <= plane + 1'b1;
          e     <= '0;
          if (plane == PL_WE) state <= (m == '0) ? S_IDLE : S_EMRD;
          else                state <= S_PST;
        end
        S_EMRD: state <= S_EMWT;
        S_EMWT: if (out_free) begin
          vtx_data.out_x       <= rdata.x;
          vtx_data.out_y       <= rdata.y;
          vtx_data.out_z       <= rdata.z;
          vtx_data.out_w       <= rdata.w;
          vtx_data.weight_b    <= rdata.wb;
          vtx_data.weight_c    <= rdata.wc;
          vtx_data.last_vertex <= (e == n - 1'b1);
          e     <= e + 1'b1;
          state <= (e == n - 1'b1) ? S_IDLE : S_EMRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_t_range, (state == S_LM) && (t > ONE_Q16))
  `ASSERT_NEVER(a_poly_range, (state == S_PEND) && (m > CNT_W'(MAX_POLY_VERTS)))

endmodule
`default_nettype wire
